>>> design/afc_pkg.sv
// Shared types and constants for the anisotropic friction coefficient block.
package afc_pkg;

	// Datapath widths
	localparam int CoefW = 16;
	localparam int MagW  = 32;
	localparam int SqW   = 63;  // square of a magnitude of at most 2^31
	localparam int DenW  = 64;  // sum of two squares
	localparam int ProdW = 95;  // axis square times velocity square
	localparam int DvdW  = 97;  // four times the weighted sum
	localparam int QuoW  = 34;  // quotient stays below 4 * 2^32
	localparam int RootW = 17;
	localparam int RemW  = 19;
	localparam int AddrW = 5;

	localparam logic [CoefW-1:0] OneQ12 = 16'd4096;
	localparam logic [CoefW-1:0] SatQ12 = 16'hFFFF;

	// Register map, word index
	typedef enum logic [2:0] {
		RegStaticX   = 3'd0,
		RegStaticY   = 3'd1,
		RegKineticX  = 3'd2,
		RegKineticY  = 3'd3,
		RegStaticIso = 3'd4,
		RegKineticIso = 3'd5,
		RegDisabled  = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] velocity_x;
		logic signed [31:0] velocity_y;
	} velocity_t;

	typedef struct packed {
		logic [CoefW-1:0] static_effective;
		logic [CoefW-1:0] kinetic_effective;
	} coef_t;

	typedef struct packed {
		logic [CoefW-1:0] static_axis_x;
		logic [CoefW-1:0] static_axis_y;
		logic [CoefW-1:0] kinetic_axis_x;
		logic [CoefW-1:0] kinetic_axis_y;
		logic [CoefW-1:0] static_isotropic;
		logic [CoefW-1:0] kinetic_isotropic;
		logic             coefficients_disabled;
	} cfg_t;

	// Travels with each word down the pipeline
	typedef struct packed {
		logic valid;
		logic dzero;
	} tag_t;

endpackage

>>> design/afc_regs.sv
// Configuration register file on the APB-style port.
module afc_regs import afc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output cfg_t             cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[AddrW-1:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Register writes; an index beyond the map is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				RegStaticX:    cfg_q.static_axis_x         <= pwdata[CoefW-1:0];
				RegStaticY:    cfg_q.static_axis_y         <= pwdata[CoefW-1:0];
				RegKineticX:   cfg_q.kinetic_axis_x        <= pwdata[CoefW-1:0];
				RegKineticY:   cfg_q.kinetic_axis_y        <= pwdata[CoefW-1:0];
				RegStaticIso:  cfg_q.static_isotropic      <= pwdata[CoefW-1:0];
				RegKineticIso: cfg_q.kinetic_isotropic     <= pwdata[CoefW-1:0];
				RegDisabled:   cfg_q.coefficients_disabled <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read-back
	always_comb begin
		prdata = '0;
		unique case (idx)
			RegStaticX:    prdata = {16'd0, cfg_q.static_axis_x};
			RegStaticY:    prdata = {16'd0, cfg_q.static_axis_y};
			RegKineticX:   prdata = {16'd0, cfg_q.kinetic_axis_x};
			RegKineticY:   prdata = {16'd0, cfg_q.kinetic_axis_y};
			RegStaticIso:  prdata = {16'd0, cfg_q.static_isotropic};
			RegKineticIso: prdata = {16'd0, cfg_q.kinetic_isotropic};
			RegDisabled:   prdata = {31'd0, cfg_q.coefficients_disabled};
			default:       prdata = '0;
		endcase
	end

endmodule

>>> design/afc_front.sv
// Front pipeline: magnitudes, squares, weighted sums and divisor.
module afc_front import afc_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  cfg_t            cfg,
	input  logic            in_valid,
	input  velocity_t       velocity,
	output tag_t            tag,
	output logic [DenW-1:0] den,
	output logic [DvdW-1:0] dvd [2]
);

	logic [2*CoefW-1:0] a2_q [4];
	logic [CoefW-1:0]   axis [4];

	tag_t               tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;
	logic [MagW-1:0]    mag_x_s1, mag_y_s1;
	logic [SqW-1:0]     sq_x_s2, sq_y_s2;
	logic [63:0]        p_lo_s3 [4];
	logic [SqW-1:0]     p_hi_s3 [4];
	logic [DenW-1:0]    den_s3, den_s4, den_s5;
	logic [ProdW-1:0]   term_s4 [4];
	logic [ProdW-1:0]   num_s5  [2];

	// Axis squares; order: static x, static y, kinetic x, kinetic y
	assign axis[0] = cfg.static_axis_x;
	assign axis[1] = cfg.static_axis_y;
	assign axis[2] = cfg.kinetic_axis_x;
	assign axis[3] = cfg.kinetic_axis_y;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) a2_q[i] <= axis[i] * axis[i];
	end

	// Valid and zero-vector tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
			tag_s5 <= '0;
		end else begin
			tag_s1.valid <= in_valid;
			tag_s1.dzero <= (velocity.velocity_x == '0) && (velocity.velocity_y == '0);
			tag_s2       <= tag_s1;
			tag_s3       <= tag_s2;
			tag_s4       <= tag_s3;
			tag_s5       <= tag_s4;
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		// s1: magnitudes, most negative value gives 2^31
		mag_x_s1     <= velocity.velocity_x[31] ? (~velocity.velocity_x + 32'd1)
			: velocity.velocity_x;
		mag_y_s1     <= velocity.velocity_y[31] ? (~velocity.velocity_y + 32'd1)
			: velocity.velocity_y;
		// s2: squares
		sq_x_s2      <= SqW'({32'd0, mag_x_s1} * {32'd0, mag_x_s1});
		sq_y_s2      <= SqW'({32'd0, mag_y_s1} * {32'd0, mag_y_s1});
		// s3: partial products on 32-bit halves, and the divisor
		for (int i = 0; i < 4; i++) begin
			p_lo_s3[i] <= a2_q[i] * ((i % 2 == 0) ? sq_x_s2[31:0] : sq_y_s2[31:0]);
			p_hi_s3[i] <= {31'd0, a2_q[i]} * {32'd0, ((i % 2 == 0) ? sq_x_s2[SqW-1:32]
				: sq_y_s2[SqW-1:32])};
		end
		den_s3       <= DenW'(sq_x_s2) + DenW'(sq_y_s2);
		// s4: recombine halves
		for (int i = 0; i < 4; i++) begin
			term_s4[i] <= ProdW'({p_hi_s3[i], 32'd0}) + ProdW'(p_lo_s3[i]);
		end
		den_s4       <= den_s3;
		// s5: weighted sums per coefficient
		num_s5[0]    <= term_s4[0] + term_s4[1];
		num_s5[1]    <= term_s4[2] + term_s4[3];
		den_s5       <= den_s4;
	end

	assign tag    = tag_s5;
	assign den    = den_s5;
	assign dvd[0] = {num_s5[0], 2'b00};
	assign dvd[1] = {num_s5[1], 2'b00};

endmodule

>>> design/afc_div.sv
// Restoring divider, one quotient bit per stage, both coefficients side by side.
module afc_div import afc_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  tag_t            tag_in,
	input  logic [DenW-1:0] den,
	input  logic [DvdW-1:0] dvd [2],
	output tag_t            tag_out,
	output logic [QuoW-1:0] quo [2]
);

	tag_t            tag_s   [1:QuoW];
	logic [DenW-1:0] den_s   [1:QuoW];
	logic [DenW-1:0] rem_s   [1:QuoW][2];
	logic [QuoW-1:0] lq_s    [1:QuoW][2];   // dividend bits out the top, quotient in

	for (genvar k = 0; k < QuoW; k++) begin : g_step
		tag_t            cur_tag;
		logic [DenW-1:0] cur_den;
		logic [DenW-1:0] cur_rem [2];
		logic [QuoW-1:0] cur_lq  [2];

		if (k == 0) begin : g_first
			assign cur_tag    = tag_in;
			assign cur_den    = den;
			assign cur_rem[0] = DenW'(dvd[0][DvdW-1:QuoW]);
			assign cur_rem[1] = DenW'(dvd[1][DvdW-1:QuoW]);
			assign cur_lq[0]  = dvd[0][QuoW-1:0];
			assign cur_lq[1]  = dvd[1][QuoW-1:0];
		end else begin : g_next
			assign cur_tag    = tag_s[k];
			assign cur_den    = den_s[k];
			assign cur_rem[0] = rem_s[k][0];
			assign cur_rem[1] = rem_s[k][1];
			assign cur_lq[0]  = lq_s[k][0];
			assign cur_lq[1]  = lq_s[k][1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) tag_s[k+1] <= '0;
			else         tag_s[k+1] <= cur_tag;
		end

		always_ff @(posedge clk) begin
			den_s[k+1] <= cur_den;
		end

		for (genvar c = 0; c < 2; c++) begin : g_ch
			logic [DenW:0] trial;
			logic [DenW:0] diff;
			logic          ge;

			// shift in next dividend bit, compare and subtract
			assign trial = {cur_rem[c], cur_lq[c][QuoW-1]};
			assign diff  = trial - {1'b0, cur_den};
			assign ge    = trial >= {1'b0, cur_den};

			always_ff @(posedge clk) begin
				rem_s[k+1][c] <= ge ? diff[DenW-1:0] : trial[DenW-1:0];
				lq_s[k+1][c]  <= {cur_lq[c][QuoW-2:0], ge};
			end
		end
	end

	assign tag_out = tag_s[QuoW];
	assign quo[0]  = lq_s[QuoW][0];
	assign quo[1]  = lq_s[QuoW][1];

endmodule

>>> design/afc_sqrt.sv
// Digit-by-digit integer square root, one root bit per stage, two lanes.
module afc_sqrt import afc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  tag_t             tag_in,
	input  logic [QuoW-1:0]  quo [2],
	output tag_t             tag_out,
	output logic [RootW-1:0] root [2]
);

	tag_t             tag_s  [1:RootW];
	logic [RemW-1:0]  rem_s  [1:RootW][2];
	logic [RootW-1:0] root_s [1:RootW][2];
	logic [QuoW-1:0]  qsh_s  [1:RootW][2];

	for (genvar k = 0; k < RootW; k++) begin : g_step
		tag_t             cur_tag;
		logic [RemW-1:0]  cur_rem  [2];
		logic [RootW-1:0] cur_root [2];
		logic [QuoW-1:0]  cur_qsh  [2];

		if (k == 0) begin : g_first
			assign cur_tag = tag_in;
			for (genvar c = 0; c < 2; c++) begin : g_init
				assign cur_rem[c]  = '0;
				assign cur_root[c] = '0;
				assign cur_qsh[c]  = quo[c];
			end
		end else begin : g_next
			assign cur_tag = tag_s[k];
			for (genvar c = 0; c < 2; c++) begin : g_init
				assign cur_rem[c]  = rem_s[k][c];
				assign cur_root[c] = root_s[k][c];
				assign cur_qsh[c]  = qsh_s[k][c];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) tag_s[k+1] <= '0;
			else         tag_s[k+1] <= cur_tag;
		end

		for (genvar c = 0; c < 2; c++) begin : g_ch
			logic [RemW+1:0] cand;
			logic [RemW+1:0] trial;
			logic            ge;

			// bring down two radicand bits, try root*4+1
			assign cand  = {cur_rem[c], cur_qsh[c][QuoW-1:QuoW-2]};
			assign trial = (RemW+2)'({cur_root[c], 2'b01});
			assign ge    = cand >= trial;

			always_ff @(posedge clk) begin
				rem_s[k+1][c]  <= ge ? RemW'(cand - trial) : RemW'(cand);
				root_s[k+1][c] <= {cur_root[c][RootW-2:0], ge};
				qsh_s[k+1][c]  <= {cur_qsh[c][QuoW-3:0], 2'b00};
			end
		end
	end

	assign tag_out = tag_s[RootW];
	assign root[0] = root_s[RootW][0];
	assign root[1] = root_s[RootW][1];

endmodule

>>> design/anisotropic_friction_coefficient.sv
// Top level of the anisotropic friction coefficient evaluator.
//
// One velocity word may be started every cycle; busy stays low. Each word gives
// one coefficient word, marked by done for a single cycle, in start order. The
// pipeline holds magnitude, square, partial-product, recombine and weighted-sum
// stages, 34 restoring-divide stages (one quotient bit each), 17 square-root
// stages (one root bit each) and the output register.
// The receiver cannot stall the result, so done must be sampled when it rises.
// Registers must be written only while no word is in flight; the block does not enforce it.
module anisotropic_friction_coefficient import afc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  velocity_t        velocity,
	output logic             done,
	output coef_t            coefficient,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	cfg_t             cfg;
	tag_t             front_tag, div_tag, sqrt_tag;
	logic [DenW-1:0]  den;
	logic [DvdW-1:0]  dvd  [2];
	logic [QuoW-1:0]  quo  [2];
	logic [RootW-1:0] root [2];
	logic [CoefW-1:0] ell  [2];
	coef_t            res;
	logic             done_q;
	coef_t            result_q;

	assign busy = 1'b0;

	afc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	afc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (start & ~busy),
		.velocity (velocity),
		.tag      (front_tag),
		.den      (den),
		.dvd      (dvd)
	);

	afc_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag_in  (front_tag),
		.den     (den),
		.dvd     (dvd),
		.tag_out (div_tag),
		.quo     (quo)
	);

	afc_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag_in  (div_tag),
		.quo     (quo),
		.tag_out (sqrt_tag),
		.root    (root)
	);

	// Round half up: largest r with 2r-1 <= root, then saturate
	for (genvar c = 0; c < 2; c++) begin : g_round
		logic [RootW:0] half;
		assign half   = (RootW+1)'(root[c]) + (RootW+1)'(1);
		assign ell[c] = half[RootW] ? SatQ12 : half[CoefW:1];
	end

	// Pick elliptical, isotropic, zero-vector or forced-one value
	always_comb begin
		if (cfg.coefficients_disabled) begin
			res.static_effective  = OneQ12;
			res.kinetic_effective = OneQ12;
		end else begin
			if (cfg.static_axis_x == '0 && cfg.static_axis_y == '0)
				res.static_effective = cfg.static_isotropic;
			else if (sqrt_tag.dzero)
				res.static_effective = cfg.static_axis_x;
			else
				res.static_effective = ell[0];
			if (cfg.kinetic_axis_x == '0 && cfg.kinetic_axis_y == '0)
				res.kinetic_effective = cfg.kinetic_isotropic;
			else if (sqrt_tag.dzero)
				res.kinetic_effective = cfg.kinetic_axis_x;
			else
				res.kinetic_effective = ell[1];
		end
	end

	// Output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else         done_q <= sqrt_tag.valid;
	end

	always_ff @(posedge clk) begin
		result_q <= res;
	end

	assign done        = done_q;
	assign coefficient = result_q;

endmodule
